// ----- rtl/pist_pkg.sv -----
// Package: types, codes and microprogram for the periodic identifier schedule table.
`default_nettype none
package pist_pkg;

  localparam int unsigned SLOTS_DEFAULT = 8;
  localparam int unsigned STEP_W = 4;

  localparam logic [3:0] MODE_FAST = 4'h1;
  localparam logic [3:0] MODE_SLOW = 4'h3;
  localparam logic [3:0] MODE_STOP = 4'h4;
  localparam logic [7:0] IDENT_FREE = 8'h00;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_RANGE = 3'd1,
    ST_COND  = 3'd2,
    ST_FULL  = 3'd3,
    ST_SKIP  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_WAIT,
    ACT_STOP,
    ACT_SCHED,
    ACT_RESP
  } act_e;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_START,
    C_FAILED,
    C_NOT_STOP,
    C_BAD_MODE,
    C_NO_READER,
    C_NO_WORK
  } cond_e;

  localparam logic [STEP_W-1:0] STEP_WAIT    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_SKIPCHK = 4'd1;
  localparam logic [STEP_W-1:0] STEP_STOPCHK = 4'd2;
  localparam logic [STEP_W-1:0] STEP_STOP    = 4'd3;
  localparam logic [STEP_W-1:0] STEP_MODECHK = 4'd4;
  localparam logic [STEP_W-1:0] STEP_RDRCHK  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_WORKCHK = 4'd6;
  localparam logic [STEP_W-1:0] STEP_SCHED   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_RESP    = 4'd8;

  typedef struct packed {
    act_e              act;
    cond_e             cond;
    logic [STEP_W-1:0] target;
    logic              load;
    status_e           stat;
  } ucode_t;

  typedef struct packed {
    act_e    act;
    logic    load;
    status_e stat;
  } ctrl_t;

  typedef struct packed {
    logic failed;
    logic not_stop;
    logic bad_mode;
    logic no_reader;
    logic no_work;
  } flags_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{act: ACT_NONE, cond: C_ALWAYS, target: STEP_WAIT, load: 1'b0, stat: ST_OK};
    unique case (step)
      STEP_WAIT:    w = '{ACT_WAIT,  C_NO_START,  STEP_WAIT,    1'b0, ST_OK};
      STEP_SKIPCHK: w = '{ACT_NONE,  C_FAILED,    STEP_RESP,    1'b1, ST_SKIP};
      STEP_STOPCHK: w = '{ACT_NONE,  C_NOT_STOP,  STEP_MODECHK, 1'b0, ST_OK};
      STEP_STOP:    w = '{ACT_STOP,  C_ALWAYS,    STEP_RESP,    1'b1, ST_OK};
      STEP_MODECHK: w = '{ACT_NONE,  C_BAD_MODE,  STEP_RESP,    1'b1, ST_RANGE};
      STEP_RDRCHK:  w = '{ACT_NONE,  C_NO_READER, STEP_RESP,    1'b1, ST_COND};
      STEP_WORKCHK: w = '{ACT_NONE,  C_NO_WORK,   STEP_RESP,    1'b1, ST_OK};
      STEP_SCHED:   w = '{ACT_SCHED, C_ALWAYS,    STEP_RESP,    1'b0, ST_OK};
      STEP_RESP:    w = '{ACT_RESP,  C_ALWAYS,    STEP_WAIT,    1'b0, ST_OK};
      default:      w = '{ACT_NONE,  C_ALWAYS,    STEP_WAIT,    1'b0, ST_OK};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/pist_seq.sv -----
// Microcode sequencer: step counter, control ROM and conditional jumps.
`default_nettype none
module pist_seq (
  input  wire                logic    clk_i,
  input  wire                logic    rst_ni,
  input  wire                logic    start_i,
  input  wire                pist_pkg::flags_t flags_i,
  output pist_pkg::ctrl_t              ctrl_o,
  output logic                         busy_o
);
  import pist_pkg::*;

  logic [STEP_W-1:0] pc_q, pc_d;
  ucode_t            uw;
  logic              taken;

  always_comb begin
    uw = ucode_rom(pc_q);
    unique case (uw.cond)
      C_ALWAYS:    taken = 1'b1;
      C_NO_START:  taken = !start_i;
      C_FAILED:    taken = flags_i.failed;
      C_NOT_STOP:  taken = flags_i.not_stop;
      C_BAD_MODE:  taken = flags_i.bad_mode;
      C_NO_READER: taken = flags_i.no_reader;
      C_NO_WORK:   taken = flags_i.no_work;
      default:     taken = 1'b1;
    endcase
    pc_d = taken ? uw.target : pc_q + STEP_W'(1);
    ctrl_o.act  = uw.act;
    ctrl_o.load = uw.load && taken;
    ctrl_o.stat = uw.stat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign busy_o = (pc_q != STEP_WAIT);

endmodule
`default_nettype wire

// ----- rtl/pist_table.sv -----
// Datapath: item latch, slot table, occupancy count, status and request-failed flag.
`default_nettype none
module pist_table #(
  parameter int unsigned SLOTS = pist_pkg::SLOTS_DEFAULT
) (
  input  wire  logic                  clk_i,
  input  wire  logic                  rst_ni,
  input  wire  logic                  start_i,
  input  wire  pist_pkg::ctrl_t       ctrl_i,
  input  wire  logic                  reader_present_i,
  input  wire  logic [3:0]            mode_i,
  input  wire  logic [7:0]            ident_i,
  input  wire  logic                  has_ident_i,
  input  wire  logic                  last_of_request_i,
  input  wire  logic [31:0]           now_ms_i,
  output pist_pkg::flags_t            flags_o,
  output pist_pkg::status_e           status_o,
  output logic [3:0]                  entry_count_o
);
  import pist_pkg::*;

  localparam int unsigned CW = $clog2(SLOTS + 1);

  logic [3:0]  mode_q;
  logic [7:0]  id_q;
  logic        has_q;
  logic        last_q;
  logic [31:0] now_q;

  logic [7:0]  ident_q [SLOTS];
  logic [7:0]  ident_d [SLOTS];
  logic [1:0]  rate_q  [SLOTS];
  logic [1:0]  rate_d  [SLOTS];
  logic [31:0] time_q  [SLOTS];
  logic [31:0] time_d  [SLOTS];
  logic [CW-1:0] count_q, count_d;
  status_e     status_q, status_d;
  logic        failed_q, failed_d;

  logic [SLOTS-1:0] match, free, first_free;
  logic             full;

  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      match[j] = (ident_q[j] == id_q);
      free[j]  = (ident_q[j] == IDENT_FREE);
    end
    first_free = free & (~free + SLOTS'(1));
    full = (count_q >= CW'(SLOTS));
  end

  always_comb begin
    ident_d  = ident_q;
    rate_d   = rate_q;
    time_d   = time_q;
    count_d  = count_q;
    status_d = status_q;
    failed_d = failed_q;
    if (ctrl_i.load) begin
      status_d = ctrl_i.stat;
    end
    unique case (ctrl_i.act)
      ACT_STOP: begin
        if (!has_q) begin
          for (int j = 0; j < SLOTS; j++) ident_d[j] = IDENT_FREE;
          count_d = '0;
        end else if (id_q != IDENT_FREE) begin
          for (int j = 0; j < SLOTS; j++) begin
            if (match[j]) ident_d[j] = IDENT_FREE;
          end
          if ((|match) && (count_q != '0)) count_d = count_q - CW'(1);
        end
      end
      ACT_SCHED: begin
        if (|match) begin
          for (int j = 0; j < SLOTS; j++) begin
            if (match[j]) rate_d[j] = mode_q[1:0];
          end
          status_d = ST_OK;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          for (int j = 0; j < SLOTS; j++) begin
            if (first_free[j]) begin
              ident_d[j] = id_q;
              rate_d[j]  = mode_q[1:0];
              time_d[j]  = now_q;
            end
          end
          if (|free) count_d = count_q + CW'(1);
          status_d = ST_OK;
        end
      end
      ACT_RESP: begin
        failed_d = last_q ? 1'b0 : (status_q != ST_OK);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < SLOTS; j++) ident_q[j] <= IDENT_FREE;
      count_q  <= '0;
      status_q <= ST_OK;
      failed_q <= 1'b0;
    end else begin
      ident_q  <= ident_d;
      count_q  <= count_d;
      status_q <= status_d;
      failed_q <= failed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rate_q <= rate_d;
    time_q <= time_d;
    if (ctrl_i.act == ACT_WAIT && start_i) begin
      mode_q <= mode_i;
      id_q   <= ident_i;
      has_q  <= has_ident_i;
      last_q <= last_of_request_i;
      now_q  <= now_ms_i;
    end
  end

  always_comb begin
    flags_o.failed    = failed_q;
    flags_o.not_stop  = (mode_q != MODE_STOP);
    flags_o.bad_mode  = (mode_q < MODE_FAST) || (mode_q > MODE_SLOW);
    flags_o.no_reader = !reader_present_i;
    flags_o.no_work   = !has_q || (id_q == IDENT_FREE);
  end

  assign status_o      = status_q;
  assign entry_count_o = 4'(count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(SLOTS))
    else $error("occupancy count above slot count");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.act == ACT_RESP && last_q) |=> !failed_q)
    else $error("request-failed flag not cleared at end of request");

  a_skip_failed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.act == ACT_RESP && status_q == ST_SKIP) |-> failed_q)
    else $error("skip status without a failed request");

endmodule
`default_nettype wire

// ----- rtl/periodic_id_schedule_table.sv -----
// Top level: periodic identifier schedule table with microcoded control.
//
// Items enter on start/busy: one is accepted at a clock edge where start is
// high and busy is low; mode_i, ident_i, has_ident_i, last_of_request_i and
// now_ms_i are sampled then. Each item yields exactly one result: done_o is
// high for one cycle with status_o and entry_count_o valid in that cycle.
// The receiver cannot stall; results must be taken as they appear.
// A microprogram runs one step per cycle. After the accept edge an item passes
// the skip check (a skipped item goes to the response step), the stop check and
// the stop step for a stop, else the mode, reader and work checks, which end in
// the response step on a bad mode, no reader or a bare or zero identifier, then
// the schedule step; busy drops the cycle after done_o, so an item's length is
// set by its path through the control ROM. All slots are compared at once.
// cfg_ready_o is always high. The user writes the reader_present register
// through cfg_valid_i/cfg_ready_o only while idle; the block does not enforce it.
// Reset clears the table, the count and the request-failed flag, and sets
// reader_present to 1.
`default_nettype none
module periodic_id_schedule_table #(
  parameter int unsigned SLOTS = pist_pkg::SLOTS_DEFAULT
) (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        start,
  output logic              busy,
  input  wire  logic [3:0]  mode_i,
  input  wire  logic [7:0]  ident_i,
  input  wire  logic        has_ident_i,
  input  wire  logic        last_of_request_i,
  input  wire  logic [31:0] now_ms_i,
  output logic              done_o,
  output logic [2:0]        status_o,
  output logic [3:0]        entry_count_o,
  input  wire  logic        cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire  logic        cfg_reader_present_i
);
  import pist_pkg::*;

  ctrl_t   ctrl;
  flags_t  flags;
  status_e status;
  logic    reader_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reader_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      reader_q <= cfg_reader_present_i;
    end
  end

  pist_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .flags_i (flags),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  pist_table #(
    .SLOTS (SLOTS)
  ) u_table (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start),
    .ctrl_i            (ctrl),
    .reader_present_i  (reader_q),
    .mode_i            (mode_i),
    .ident_i           (ident_i),
    .has_ident_i       (has_ident_i),
    .last_of_request_i (last_of_request_i),
    .now_ms_i          (now_ms_i),
    .flags_o           (flags),
    .status_o          (status),
    .entry_count_o     (entry_count_o)
  );

  assign done_o   = (ctrl.act == ACT_RESP);
  assign status_o = status;

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe outside a busy period");

  a_done_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("busy held after the result");

endmodule
`default_nettype wire
